// File: rtl/core/number_announcement_queue_macros.svh
`ifndef NUMBER_ANNOUNCEMENT_QUEUE_MACROS_SVH
`define NUMBER_ANNOUNCEMENT_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define NANQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NANQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/nanq_pkg.sv
`timescale 1ns / 1ps

package nanq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int CLIP_W   = 16;
    localparam int NUM_W    = 15;
    localparam int TICK_W   = 8;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int THOU_W   = 5;
    localparam int REM_W    = 10;
    localparam int HUND_W   = 4;
    localparam int UNIT_W   = 7;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CLIP_W-1:0] clip_t;
    typedef logic [TICK_W-1:0] tick_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_ANNOUNCE = 3'd0,
        REQ_ENQUEUE  = 3'd1,
        REQ_TICK     = 3'd2,
        REQ_PLAY     = 3'd3,
        REQ_CLEAR    = 3'd4
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_EMPTY   = 2'd0,
        STAT_PLAYING = 2'd1,
        STAT_STARTED = 2'd2,
        STAT_DONE    = 2'd3
    } stat_t;

    localparam logic REG_IDX_BASE    = 1'b0;
    localparam logic REG_IDX_TIMEOUT = 1'b1;

    localparam clip_t CODE_ZERO      = 16'd200;
    localparam clip_t CODE_MINUS     = 16'd54;
    localparam clip_t CODE_THOUSANDS = 16'd310;
    localparam clip_t CODE_HUNDREDS  = 16'd300;
    localparam clip_t CODE_UNITS     = 16'd200;
    localparam tick_t TIMEOUT_RESET  = 8'd30;

    // reciprocal constants, exact over the magnitude range
    localparam logic [NUM_W-1:0] DIV1000_MUL   = 15'd16778;
    localparam int               DIV1000_SHIFT = 24;
    localparam logic [15:0]      DIV100_MUL    = 16'd41;
    localparam int               DIV100_SHIFT  = 12;
    localparam logic [NUM_W-1:0] THOUSAND      = 15'd1000;
    localparam logic [REM_W-1:0] HUNDRED       = 10'd100;

    localparam ptr_t PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    typedef struct packed {
        clip_t announce_base;
        tick_t start_timeout_ticks;
    } cfg_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_inc = (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
    endfunction

endpackage

// File: rtl/core/number_announcement_queue.sv
`timescale 1ns / 1ps
// requests are taken only in idle; ST_RESP loads the result once the output is free
// announce first passes the divide and push states, so one request is in flight at a time
// announce pushes at most one clip a cycle through the single ram write port
// result waits in an output register while the next request is taken
// reset (async, rst_n low) empties the ring, stops the countdown and loads register defaults

`include "number_announcement_queue_macros.svh"

module number_announcement_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nanq_pkg::ADDR_W-1:0]       paddr,
    input  logic [nanq_pkg::DATA_W-1:0]      pwdata,
    output logic [nanq_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [nanq_pkg::REQ_W-1:0]        req_type,
    input  logic signed [nanq_pkg::NUM_W-1:0] number_value,
    input  logic [nanq_pkg::CLIP_W-1:0]       clip_code,
    input  logic                              busy_level,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [nanq_pkg::STAT_W-1:0]       play_status,
    output logic                              start_clip,
    output logic [nanq_pkg::CLIP_W-1:0]       clip_out,
    output logic                              sound_active
);

    nanq_pkg::cfg_t  cfg_reg;
    logic            cfg_wr;
    logic            wr_en;
    nanq_pkg::ptr_t  wr_addr;
    nanq_pkg::clip_t wr_data;
    logic            rd_en;
    nanq_pkg::ptr_t  rd_addr;
    nanq_pkg::clip_t rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.announce_base       <= '0;
            cfg_reg.start_timeout_ticks <= nanq_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                nanq_pkg::REG_IDX_BASE:
                begin
                    cfg_reg.announce_base <= pwdata[nanq_pkg::CLIP_W-1:0];
                end
                nanq_pkg::REG_IDX_TIMEOUT:
                begin
                    cfg_reg.start_timeout_ticks <= pwdata[nanq_pkg::TICK_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            nanq_pkg::REG_IDX_BASE:
            begin
                prdata = nanq_pkg::DATA_W'(cfg_reg.announce_base);
            end
            nanq_pkg::REG_IDX_TIMEOUT:
            begin
                prdata = nanq_pkg::DATA_W'(cfg_reg.start_timeout_ticks);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    nanq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .number_value (number_value),
        .clip_code    (clip_code),
        .busy_level   (busy_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .play_status  (play_status),
        .start_clip   (start_clip),
        .clip_out     (clip_out),
        .sound_active (sound_active),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    nanq_ram #(
        .DEPTH (nanq_pkg::QUEUE_DEPTH),
        .WIDTH (nanq_pkg::CLIP_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    `NANQ_ASSERT_NOW(a_start_status, out_valid, start_clip == (play_status == nanq_pkg::STAT_STARTED), "start_clip and play_status disagree")
    `NANQ_ASSERT_NOW(a_clip_zero, out_valid && !start_clip, clip_out == '0, "clip_out not zero without start")
    `NANQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while one is in flight")

endmodule

// File: rtl/core/nanq_ram.sv
`timescale 1ns / 1ps

module nanq_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/nanq_ctrl.sv
`timescale 1ns / 1ps

module nanq_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nanq_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [nanq_pkg::REQ_W-1:0]     req_type,
    input  logic signed [nanq_pkg::NUM_W-1:0] number_value,
    input  logic [nanq_pkg::CLIP_W-1:0]    clip_code,
    input  logic                           busy_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nanq_pkg::STAT_W-1:0]    play_status,
    output logic                           start_clip,
    output logic [nanq_pkg::CLIP_W-1:0]    clip_out,
    output logic                           sound_active,
    output logic                           wr_en,
    output nanq_pkg::ptr_t                 wr_addr,
    output nanq_pkg::clip_t                wr_data,
    output logic                           rd_en,
    output nanq_pkg::ptr_t                 rd_addr,
    input  nanq_pkg::clip_t                rd_data
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_DIV_K   = 9'b000000010,
        ST_DIV_H   = 9'b000000100,
        ST_DIV_U   = 9'b000001000,
        ST_P_MINUS = 9'b000010000,
        ST_P_THOU  = 9'b000100000,
        ST_P_HUND  = 9'b001000000,
        ST_P_UNIT  = 9'b010000000,
        ST_RESP    = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    nanq_pkg::ptr_t         rptr_reg, rptr_next;
    nanq_pkg::ptr_t         wptr_reg, wptr_next;
    nanq_pkg::tick_t        guard_reg, guard_next;
    logic                   busy_prev_reg, busy_prev_next;
    logic                   busy_cap_reg, busy_cap_next;
    nanq_pkg::stat_t        status_reg, status_next;
    logic                   start_reg, start_next;

    logic                   out_valid_reg, out_valid_next;
    nanq_pkg::stat_t        out_status_reg, out_status_next;
    logic                   out_start_reg, out_start_next;
    nanq_pkg::clip_t        out_clip_reg, out_clip_next;
    logic                   out_sound_reg, out_sound_next;

    logic [nanq_pkg::NUM_W-1:0]  mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic                        zero_reg, zero_next;
    logic [nanq_pkg::THOU_W-1:0] thou_reg, thou_next;
    logic [nanq_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [nanq_pkg::HUND_W-1:0] hund_reg, hund_next;

    logic                        accept;
    logic                        out_free;
    nanq_pkg::req_t              req;
    logic [nanq_pkg::NUM_W-1:0]  num_raw;
    logic [2*nanq_pkg::NUM_W-1:0] prod_k;
    logic [nanq_pkg::NUM_W-1:0]  thou_scaled;
    logic [nanq_pkg::NUM_W-1:0]  rem_calc;
    logic [15:0]                 prod_h;
    logic [nanq_pkg::REM_W-1:0]  hund_scaled;
    logic [nanq_pkg::REM_W-1:0]  unit_calc;
    logic [nanq_pkg::UNIT_W-1:0] units;
    nanq_pkg::clip_t             base;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign req      = nanq_pkg::req_t'(req_type);
    assign num_raw  = unsigned'(number_value);
    assign base     = cfg.announce_base;

    // digit split datapath
    assign prod_k      = {{nanq_pkg::NUM_W{1'b0}}, mag_reg}
                         * {{nanq_pkg::NUM_W{1'b0}}, nanq_pkg::DIV1000_MUL};
    assign thou_scaled = nanq_pkg::NUM_W'({10'd0, thou_reg} * nanq_pkg::THOUSAND);
    assign rem_calc    = mag_reg - thou_scaled;
    assign prod_h      = {6'd0, rem_reg} * nanq_pkg::DIV100_MUL;
    assign hund_scaled = nanq_pkg::REM_W'({6'd0, hund_reg} * nanq_pkg::HUNDRED);
    assign unit_calc   = rem_reg - hund_scaled;
    assign units       = unit_calc[nanq_pkg::UNIT_W-1:0];

    assign rd_addr = rptr_reg;
    assign wr_addr = wptr_reg;

    always_comb
    begin
        state_next      = state_reg;
        rptr_next       = rptr_reg;
        wptr_next       = wptr_reg;
        guard_next      = guard_reg;
        busy_prev_next  = busy_prev_reg;
        busy_cap_next   = busy_cap_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_clip_next   = out_clip_reg;
        out_sound_next  = out_sound_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;
        thou_next       = thou_reg;
        rem_next        = rem_reg;
        hund_next       = hund_reg;
        wr_en           = 1'b0;
        wr_data         = clip_code;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    busy_cap_next = busy_level;
                    status_next   = nanq_pkg::STAT_DONE;
                    start_next    = 1'b0;
                    state_next    = ST_RESP;
                    case (req)
                        nanq_pkg::REQ_ANNOUNCE:
                        begin
                            zero_next  = (num_raw == '0);
                            neg_next   = num_raw[nanq_pkg::NUM_W-1];
                            mag_next   = num_raw[nanq_pkg::NUM_W-1]
                                         ? nanq_pkg::NUM_W'(~num_raw + 1'b1) : num_raw;
                            state_next = ST_DIV_K;
                        end
                        nanq_pkg::REQ_ENQUEUE:
                        begin
                            wr_en = 1'b1;
                        end
                        nanq_pkg::REQ_TICK:
                        begin
                            if (guard_reg != '0)
                            begin
                                guard_next     = (busy_prev_reg && !busy_level)
                                                 ? '0 : nanq_pkg::tick_t'(guard_reg - 1'b1);
                                busy_prev_next = busy_level;
                            end
                        end
                        nanq_pkg::REQ_PLAY:
                        begin
                            if (guard_reg == '0 && busy_level)
                            begin
                                if (rptr_reg == wptr_reg)
                                begin
                                    status_next = nanq_pkg::STAT_EMPTY;
                                end
                                else
                                begin
                                    rd_en          = 1'b1;
                                    rptr_next      = nanq_pkg::ptr_inc(rptr_reg);
                                    guard_next     = cfg.start_timeout_ticks;
                                    busy_prev_next = busy_level;
                                    start_next     = 1'b1;
                                    status_next    = nanq_pkg::STAT_STARTED;
                                end
                            end
                            else
                            begin
                                status_next = nanq_pkg::STAT_PLAYING;
                            end
                        end
                        nanq_pkg::REQ_CLEAR:
                        begin
                            rptr_next = '0;
                        end
                        default:
                        begin
                            status_next = nanq_pkg::STAT_DONE;
                        end
                    endcase
                end
            end
            ST_DIV_K:
            begin
                thou_next  = prod_k[nanq_pkg::DIV1000_SHIFT +: nanq_pkg::THOU_W];
                state_next = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                rem_next   = rem_calc[nanq_pkg::REM_W-1:0];
                state_next = ST_DIV_U;
            end
            ST_DIV_U:
            begin
                hund_next  = prod_h[nanq_pkg::DIV100_SHIFT +: nanq_pkg::HUND_W];
                state_next = ST_P_MINUS;
            end
            ST_P_MINUS:
            begin
                wr_en      = neg_reg;
                wr_data    = base + nanq_pkg::CODE_MINUS;
                state_next = ST_P_THOU;
            end
            ST_P_THOU:
            begin
                wr_en      = (thou_reg != '0);
                wr_data    = base + nanq_pkg::CODE_THOUSANDS + nanq_pkg::CLIP_W'(thou_reg);
                state_next = ST_P_HUND;
            end
            ST_P_HUND:
            begin
                wr_en      = (hund_reg != '0);
                wr_data    = base + nanq_pkg::CODE_HUNDREDS + nanq_pkg::CLIP_W'(hund_reg);
                state_next = ST_P_UNIT;
            end
            ST_P_UNIT:
            begin
                wr_en      = (units != '0) || zero_reg;
                wr_data    = base + nanq_pkg::CODE_UNITS + nanq_pkg::CLIP_W'(units);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_start_next  = start_reg;
                    out_clip_next   = start_reg ? rd_data : '0;
                    out_sound_next  = !(guard_reg == '0 && busy_cap_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // clear wins over any pointer move
        if (accept && req == nanq_pkg::REQ_CLEAR)
        begin
            wptr_next = '0;
        end
        else if (wr_en)
        begin
            wptr_next = nanq_pkg::ptr_inc(wptr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rptr_reg       <= '0;
            wptr_reg       <= '0;
            guard_reg      <= '0;
            busy_prev_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rptr_reg       <= rptr_next;
            wptr_reg       <= wptr_next;
            guard_reg      <= guard_next;
            busy_prev_reg  <= busy_prev_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        busy_cap_reg   <= busy_cap_next;
        status_reg     <= status_next;
        start_reg      <= start_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_clip_reg   <= out_clip_next;
        out_sound_reg  <= out_sound_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        zero_reg       <= zero_next;
        thou_reg       <= thou_next;
        rem_reg        <= rem_next;
        hund_reg       <= hund_next;
    end

    assign out_valid    = out_valid_reg;
    assign play_status  = out_status_reg;
    assign start_clip   = out_start_reg;
    assign clip_out     = out_clip_reg;
    assign sound_active = out_sound_reg;

endmodule
